// File: rtl/mpt_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types of the max priority table.
// Used by mpt_best and max_priority_table_with_update_core; depends on nothing.
package mpt_pkg;

  localparam int unsigned EntryCount  = 64;
  localparam int unsigned IdBits      = 6;
  localparam int unsigned LevelBits   = 32;
  localparam int unsigned AmountBits  = 32;
  localparam int unsigned ArrivalBits = 32;
  localparam int unsigned WordBits    = LevelBits + ArrivalBits;

  typedef enum logic [1:0] {
    CmdInsert   = 2'd0,
    CmdIncrease = 2'd1,
    CmdRemove   = 2'd2,
    CmdQuery    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StatOk      = 2'd0,
    StatEmpty   = 2'd1,
    StatAbsent  = 2'd2,
    StatPresent = 2'd3
  } status_e;

  typedef struct packed {
    logic              clear;
    logic              cand_live;
    logic [IdBits-1:0] cand_id;
  } scan_ctl_t;

endpackage

// File: rtl/mpt_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// Depends on nothing.
module mpt_ram #(
  parameter int unsigned Depth    = 64,
  parameter int unsigned Width    = 64,
  parameter int unsigned AddrBits = $clog2(Depth)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrBits-1:0] waddr_i,
  input  logic [Width-1:0]    wdata_i,
  input  logic                re_i,
  input  logic [AddrBits-1:0] raddr_i,
  output logic [Width-1:0]    rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/mpt_best.sv
`timescale 1ns / 1ps
// Running best-entry tracker for the query scan of the max priority table.
// Depends on mpt_pkg.
module mpt_best (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mpt_pkg::scan_ctl_t            ctl_i,
  input  logic [mpt_pkg::WordBits-1:0]  word_i,
  output logic                          found_o,
  output logic [mpt_pkg::IdBits-1:0]    best_id_o
);

  logic                            found_q, found_d;
  logic [mpt_pkg::LevelBits-1:0]   level_q, level_d;
  logic [mpt_pkg::ArrivalBits-1:0] arrival_q, arrival_d;
  logic [mpt_pkg::IdBits-1:0]      id_q, id_d;
  logic [mpt_pkg::LevelBits-1:0]   cand_level;
  logic [mpt_pkg::ArrivalBits-1:0] cand_arrival;
  logic                            better;

  assign cand_level   = word_i[mpt_pkg::WordBits-1:mpt_pkg::ArrivalBits];
  assign cand_arrival = word_i[mpt_pkg::ArrivalBits-1:0];

  // Strict comparison keeps the lowest id when level and stamp are equal.
  assign better = !found_q || (cand_level > level_q) ||
                  ((cand_level == level_q) && (cand_arrival < arrival_q));

  always_comb begin
    found_d   = found_q;
    level_d   = level_q;
    arrival_d = arrival_q;
    id_d      = id_q;
    if (ctl_i.clear) begin
      found_d = 1'b0;
    end else if (ctl_i.cand_live && better) begin
      found_d   = 1'b1;
      level_d   = cand_level;
      arrival_d = cand_arrival;
      id_d      = ctl_i.cand_id;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    level_q   <= level_d;
    arrival_q <= arrival_d;
    id_q      <= id_d;
  end

  assign found_o   = found_q;
  assign best_id_o = id_q;

endmodule

// File: rtl/max_priority_table_with_update_core.sv
`timescale 1ns / 1ps
// Top level of the indexed max priority table with increase and remove.
// Depends on mpt_pkg, mpt_ram and mpt_best.
//
//   Channel   Direction   Handshake                 Payload
//   request   in          in_valid_i / in_ready_o   command_i, entry_id_i, amount_i
//   result    out         out_valid_o / out_ready_i status_o, best_id_o, best_valid_o
//
// Insert, remove and refused requests go from idle straight to push; an increase of a live
// entry passes the modify state between them (read, modify and write back).
// A query does one RAM read per entry through the single read port in the scan state, then drains.
// Reset clears the valid bits and the arrival counter; the RAM needs no clearing.
// One request is in work at a time; a finished result waits in the output register
// while the next request is accepted, and a request holds in its last cycle while that
// register is still full.
module max_priority_table_with_update_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        command_i,
  input  logic [mpt_pkg::IdBits-1:0]        entry_id_i,
  input  logic [mpt_pkg::AmountBits-1:0]    amount_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        status_o,
  output logic [mpt_pkg::IdBits-1:0]        best_id_o,
  output logic                              best_valid_o
);

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StMod   = 5'b00010,
    StScan  = 5'b00100,
    StDrain = 5'b01000,
    StPush  = 5'b10000
  } state_e;

  state_e                           state_q, state_d;
  logic [mpt_pkg::EntryCount-1:0]   valid_q, valid_d;
  logic [mpt_pkg::ArrivalBits-1:0]  arrival_q, arrival_d;
  logic [mpt_pkg::IdBits-1:0]       scan_q, scan_d;
  logic                             live_q, live_d;
  logic [mpt_pkg::IdBits-1:0]       tag_q, tag_d;
  mpt_pkg::cmd_e                    cmd_q, cmd_d;
  logic [mpt_pkg::IdBits-1:0]       id_q, id_d;
  logic [mpt_pkg::AmountBits-1:0]   amt_q, amt_d;
  mpt_pkg::status_e                 res_q, res_d;

  logic                             out_valid_q, out_valid_d;
  logic [1:0]                       status_q, status_d;
  logic [mpt_pkg::IdBits-1:0]       best_id_q, best_id_d;
  logic                             best_valid_q, best_valid_d;

  logic                             accept;
  logic                             we;
  logic [mpt_pkg::IdBits-1:0]       waddr;
  logic [mpt_pkg::WordBits-1:0]     wdata;
  logic                             re;
  logic [mpt_pkg::IdBits-1:0]       raddr;
  logic [mpt_pkg::WordBits-1:0]     rdata;
  logic [mpt_pkg::LevelBits:0]      sum;
  logic [mpt_pkg::LevelBits-1:0]    new_level;
  mpt_pkg::scan_ctl_t               scan_ctl;
  logic                             found;
  logic [mpt_pkg::IdBits-1:0]       found_id;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;

  assign sum = {1'b0, rdata[mpt_pkg::WordBits-1:mpt_pkg::ArrivalBits]} + {1'b0, amt_q};
  assign new_level = sum[mpt_pkg::LevelBits] ? {mpt_pkg::LevelBits{1'b1}}
                                             : sum[mpt_pkg::LevelBits-1:0];

  always_comb begin
    state_d      = state_q;
    valid_d      = valid_q;
    arrival_d    = arrival_q;
    scan_d       = scan_q;
    live_d       = 1'b0;
    tag_d        = scan_q;
    cmd_d        = cmd_q;
    id_d         = id_q;
    amt_d        = amt_q;
    res_d        = res_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    status_d     = status_q;
    best_id_d    = best_id_q;
    best_valid_d = best_valid_q;
    we           = 1'b0;
    waddr        = entry_id_i;
    wdata        = {amount_i, arrival_q};
    re           = 1'b0;
    raddr        = entry_id_i;
    scan_ctl     = '{clear: 1'b0, cand_live: live_q, cand_id: tag_q};

    case (state_q)
      StIdle: begin
        if (accept) begin
          cmd_d   = mpt_pkg::cmd_e'(command_i);
          id_d    = entry_id_i;
          amt_d   = amount_i;
          res_d   = mpt_pkg::StatOk;
          state_d = StPush;
          case (mpt_pkg::cmd_e'(command_i))
            mpt_pkg::CmdInsert: begin
              if (valid_q[entry_id_i]) begin
                res_d = mpt_pkg::StatPresent;
              end else begin
                we                  = 1'b1;
                valid_d[entry_id_i] = 1'b1;
                arrival_d           = arrival_q + 1'b1;
              end
            end
            mpt_pkg::CmdIncrease: begin
              if (valid_q[entry_id_i]) begin
                re      = 1'b1;
                state_d = StMod;
              end else begin
                res_d = mpt_pkg::StatAbsent;
              end
            end
            mpt_pkg::CmdRemove: begin
              if (valid_q[entry_id_i]) begin
                valid_d[entry_id_i] = 1'b0;
              end else begin
                res_d = mpt_pkg::StatAbsent;
              end
            end
            mpt_pkg::CmdQuery: begin
              scan_ctl.clear = 1'b1;
              scan_d         = '0;
              state_d        = StScan;
            end
            default: begin
              state_d = StPush;
            end
          endcase
        end
      end
      StMod: begin
        we      = 1'b1;
        waddr   = id_q;
        wdata   = {new_level, rdata[mpt_pkg::ArrivalBits-1:0]};
        state_d = StPush;
      end
      StScan: begin
        re     = 1'b1;
        raddr  = scan_q;
        live_d = valid_q[scan_q];
        tag_d  = scan_q;
        scan_d = scan_q + 1'b1;
        if (scan_q == mpt_pkg::IdBits'(mpt_pkg::EntryCount - 1)) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StPush;
      end
      StPush: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          if (cmd_q == mpt_pkg::CmdQuery) begin
            status_d     = found ? mpt_pkg::StatOk : mpt_pkg::StatEmpty;
            best_id_d    = found ? found_id : '0;
            best_valid_d = found;
          end else begin
            status_d     = res_q;
            best_id_d    = '0;
            best_valid_d = 1'b0;
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      valid_q     <= '0;
      arrival_q   <= '0;
      live_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      arrival_q   <= arrival_d;
      live_q      <= live_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q       <= scan_d;
    tag_q        <= tag_d;
    cmd_q        <= cmd_d;
    id_q         <= id_d;
    amt_q        <= amt_d;
    res_q        <= res_d;
    status_q     <= status_d;
    best_id_q    <= best_id_d;
    best_valid_q <= best_valid_d;
  end

  mpt_ram #(
    .Depth (mpt_pkg::EntryCount),
    .Width (mpt_pkg::WordBits)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  mpt_best u_best (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (scan_ctl),
    .word_i    (rdata),
    .found_o   (found),
    .best_id_o (found_id)
  );

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign best_id_o    = best_id_q;
  assign best_valid_o = best_valid_q;

`ifndef NO_ASSERTIONS
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("A second request was accepted while one is in work.");

  a_best_means_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && best_valid_o) |-> (status_o == mpt_pkg::StatOk))
    else $error("A query answer carries a status other than ok.");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == StIdle || state_q == StMod))
    else $error("The table was written outside an insert or an increase.");

  a_mod_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMod) |-> $past(re))
    else $error("An increase wrote back without reading the entry first.");
`endif

endmodule
